// File: src/lzssd_pkg.sv
// lzssd_pkg: shared constants and types of the lzss window decompressor
// no dependencies; imported by the front, back, outq and top modules

package lzssd_pkg;

    localparam int WINDOW_BYTES = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_BYTES);
    localparam int PC_W         = WIN_AW + 1;
    localparam int LEN_BIAS     = 3;
    localparam int LEN_MASK     = 'hF;
    localparam int DIST_SHIFT   = 4;
    localparam int LEN_TOP      = LEN_MASK + LEN_BIAS;
    localparam int REM_W        = $clog2(LEN_TOP + 1);
    localparam int GROUP_TOKENS = 8;
    localparam int FLAG_CNT_W   = $clog2(GROUP_TOKENS + 1);

    // queue depths, powers of two
    localparam int TQ_DEPTH = 2;
    localparam int TQ_AW    = $clog2(TQ_DEPTH);
    localparam int TQ_CW    = $clog2(TQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // literal: byte in lo; match: code is {hi, lo}
    typedef struct packed {
        logic       clr;
        logic       is_copy;
        logic [7:0] hi;
        logic [7:0] lo;
    } t_token;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       bad_reference;
    } t_result;

endpackage

// File: src/lzssd_ram.sv
// lzssd_ram: generic single-write, single-read ram with registered read
// no dependencies

module lzssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// File: src/lzssd_front.sv
// lzssd_front: stream parser turning compressed bytes into literal and match tokens,
// with the token queue towards the copy engine; depends on lzssd_pkg

module lzssd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [7:0]        i_in_byte,
    input  logic              i_stream_start,
    output lzssd_pkg::t_token o_tok,
    output logic              o_tok_vld,
    input  logic              i_tok_take
);
    import lzssd_pkg::*;

    logic [7:0]            r_flag_shift, n_flag_shift;
    logic [FLAG_CNT_W-1:0] r_flags_left, n_flags_left;
    logic                  r_awaiting, n_awaiting;
    logic [7:0]            r_saved_high, n_saved_high;
    logic                  r_pend_clr, n_pend_clr;

    t_token                r_q [TQ_DEPTH];
    logic [TQ_AW-1:0]      r_wr;
    logic [TQ_AW-1:0]      r_rd;
    logic [TQ_CW-1:0]      r_cnt;

    logic                  acc;
    logic                  enq;
    logic                  deq;
    t_token                tok;

    assign o_full    = (r_cnt == TQ_CW'(TQ_DEPTH));
    assign o_tok_vld = (r_cnt != '0);
    assign o_tok     = r_q[r_rd];
    assign acc       = i_push && !o_full;
    assign deq       = i_tok_take && o_tok_vld;

    always_comb begin
        n_flag_shift = r_flag_shift;
        n_flags_left = r_flags_left;
        n_awaiting   = r_awaiting;
        n_saved_high = r_saved_high;
        n_pend_clr   = r_pend_clr;
        enq          = 1'b0;
        tok.clr      = r_pend_clr;
        tok.is_copy  = 1'b0;
        tok.hi       = r_saved_high;
        tok.lo       = i_in_byte;
        if (acc) begin
            if (i_stream_start) begin
                // new stream: pending flags and match high byte dropped
                n_flag_shift = i_in_byte;
                n_flags_left = FLAG_CNT_W'(GROUP_TOKENS);
                n_awaiting   = 1'b0;
                n_saved_high = '0;
                n_pend_clr   = 1'b1;
            end else if (r_awaiting) begin
                enq          = 1'b1;
                tok.is_copy  = 1'b1;
                n_awaiting   = 1'b0;
                n_pend_clr   = 1'b0;
            end else if (r_flags_left == '0) begin
                n_flag_shift = i_in_byte;
                n_flags_left = FLAG_CNT_W'(GROUP_TOKENS);
            end else begin
                n_flag_shift = {1'b0, r_flag_shift[7:1]};
                n_flags_left = r_flags_left - 1'b1;
                if (r_flag_shift[0]) begin
                    n_saved_high = i_in_byte;
                    n_awaiting   = 1'b1;
                end else begin
                    enq        = 1'b1;
                    n_pend_clr = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_shift <= '0;
            r_flags_left <= '0;
            r_awaiting   <= 1'b0;
            r_saved_high <= '0;
            r_pend_clr   <= 1'b0;
            r_wr         <= '0;
            r_rd         <= '0;
            r_cnt        <= '0;
        end else begin
            r_flag_shift <= n_flag_shift;
            r_flags_left <= n_flags_left;
            r_awaiting   <= n_awaiting;
            r_saved_high <= n_saved_high;
            r_pend_clr   <= n_pend_clr;
            if (enq) begin
                r_wr <= r_wr + 1'b1;
            end
            if (deq) begin
                r_rd <= r_rd + 1'b1;
            end
            if (enq && !deq) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (deq && !enq) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr] <= tok;
        end
    end

endmodule

// File: src/lzssd_back.sv
// lzssd_back: copy engine executing tokens one output byte per cycle while i_room
// is high, over the history window ram; depends on lzssd_pkg and lzssd_ram

module lzssd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lzssd_pkg::t_token  i_tok,
    input  logic               i_tok_vld,
    output logic               o_tok_take,
    input  logic               i_room,
    output logic               o_res_vld,
    output lzssd_pkg::t_result o_res
);
    import lzssd_pkg::*;

    t_token             r_tok;
    logic [REM_W-1:0]   r_rem;
    logic [WIN_AW-1:0]  r_wp;
    logic [PC_W-1:0]    r_pc;
    logic               r_first;
    logic               r_bad;

    logic               r_b_vld;
    logic               r_b_lit;
    logic               r_b_zero;
    logic               r_b_fwd;
    logic [7:0]         r_b_lo;
    logic               r_b_last;
    logic               r_b_bad;
    logic [WIN_AW-1:0]  r_b_waddr;
    logic [7:0]         r_last_byte;

    logic [WIN_AW-1:0]  code_hi;
    logic [PC_W-1:0]    offs;
    logic               issue;
    logic               zero;
    logic               bad_now;
    logic [REM_W-1:0]   load_len;
    logic [WIN_AW-1:0]  raddr;
    logic [7:0]         ram_q;
    logic [7:0]         b_byte;

    assign code_hi  = {r_tok.hi, r_tok.lo[7:DIST_SHIFT]};
    assign offs     = {1'b0, code_hi} + 1'b1;
    assign issue    = (r_rem != '0) && i_room;
    // source before the stream start reads as zero
    assign zero     = r_tok.is_copy && (r_pc < offs);
    assign bad_now  = r_first ? zero : r_bad;
    assign raddr    = r_wp + ~code_hi;
    assign load_len = i_tok.is_copy
                    ? REM_W'(i_tok.lo[DIST_SHIFT-1:0]) + REM_W'(LEN_BIAS)
                    : REM_W'(1);

    assign o_tok_take = i_tok_vld && ((r_rem == '0) || (issue && r_rem == REM_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_wp    <= '0;
            r_pc    <= '0;
            r_first <= 1'b0;
            r_bad   <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= issue;
            if (issue) begin
                r_wp <= r_wp + 1'b1;
            end
            if (o_tok_take && i_tok.clr) begin
                r_pc <= '0;
            end else if (issue && r_pc != PC_W'(WINDOW_BYTES)) begin
                r_pc <= r_pc + 1'b1;
            end
            if (o_tok_take) begin
                r_rem   <= load_len;
                r_first <= 1'b1;
            end else if (issue) begin
                r_rem   <= r_rem - 1'b1;
                r_first <= 1'b0;
            end
            if (issue && r_first) begin
                r_bad <= zero;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_take) begin
            r_tok <= i_tok;
        end
        if (issue) begin
            r_b_lit   <= !r_tok.is_copy;
            r_b_zero  <= zero;
            r_b_fwd   <= (code_hi == '0);
            r_b_lo    <= r_tok.lo;
            r_b_last  <= (r_rem == REM_W'(1));
            r_b_bad   <= bad_now;
            r_b_waddr <= r_wp;
        end
        if (r_b_vld) begin
            r_last_byte <= b_byte;
        end
    end

    // distance one reads the byte being written, taken from the bypass register
    always_comb begin
        if (r_b_lit) begin
            b_byte = r_b_lo;
        end else if (r_b_zero) begin
            b_byte = '0;
        end else if (r_b_fwd) begin
            b_byte = r_last_byte;
        end else begin
            b_byte = ram_q;
        end
    end

    lzssd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (r_b_vld),
        .i_waddr (r_b_waddr),
        .i_wdata (b_byte),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    assign o_res_vld           = r_b_vld;
    assign o_res.out_byte      = b_byte;
    assign o_res.last_of_run   = r_b_last;
    assign o_res.bad_reference = r_b_bad;

endmodule

// File: src/lzssd_outq.sv
// lzssd_outq: result queue between the copy engine and the result port
// depends on lzssd_pkg

module lzssd_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lzssd_pkg::t_result i_res,
    output logic               o_room,
    output logic               o_empty,
    input  logic               i_pop,
    output lzssd_pkg::t_result o_res
);
    import lzssd_pkg::*;

    t_result          r_q [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wr;
    logic [OQ_AW-1:0] r_rd;
    logic [OQ_CW-1:0] r_cnt;
    logic             deq;

    assign o_empty = (r_cnt == '0);
    // room for one beat in flight plus one more
    assign o_room  = (r_cnt <= OQ_CW'(OQ_DEPTH - 2));
    assign o_res   = r_q[r_rd];
    assign deq     = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (deq) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !deq) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (deq && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_res;
        end
    end

endmodule

// File: src/lzss_window_decompressor.sv
// lzss_window_decompressor: top level of the lzss decompressor with 4096-byte window
// depends on lzssd_pkg, lzssd_front, lzssd_back, lzssd_outq
//
// input side is a queue: a beat of compressed stream (i_in_byte, i_stream_start)
// is taken when push is high and full is low. result side is a queue: the oldest
// decompressed byte sits on o_out_byte, o_last_of_run and o_bad_reference while
// empty is low, and leaves on a cycle with pop high.
// the parser takes one beat per cycle, while full is low, into a two-entry token
// queue. the copy engine writes one byte per cycle while the result queue has room,
// set by the single window ram write port: a literal gives one byte, a match of
// length 3 to 18 that many. flag bytes and match high bytes give no result. the
// first result of a token passes the token queue, the engine's token register, its
// write stage and the result queue. overlapping copies with distance one are served
// from a bypass register. reset clears parser, queues and pointers; the window
// needs no clearing pass, because a window byte is only used once it was written in
// the current stream. when the receiver stalls the result queue fills, the copy
// engine waits, the token queue fills and full rises; nothing is lost.

module lzss_window_decompressor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_stream_start,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_bad_reference
);
    import lzssd_pkg::*;

    t_token  tok;
    logic    tok_vld;
    logic    tok_take;
    logic    room;
    logic    res_vld;
    t_result res;
    t_result head;

    lzssd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_in_byte      (i_in_byte),
        .i_stream_start (i_stream_start),
        .o_tok          (tok),
        .o_tok_vld      (tok_vld),
        .i_tok_take     (tok_take)
    );

    lzssd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tok      (tok),
        .i_tok_vld  (tok_vld),
        .o_tok_take (tok_take),
        .i_room     (room),
        .o_res_vld  (res_vld),
        .o_res      (res)
    );

    lzssd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld),
        .i_res   (res),
        .o_room  (room),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (head)
    );

    assign o_out_byte      = head.out_byte;
    assign o_last_of_run   = head.last_of_run;
    assign o_bad_reference = head.bad_reference;

endmodule

// File: src/lzssd_chk.sv
// lzssd_chk: port-level checks of the lzss window decompressor and their bind
// depends on lzss_window_decompressor ports only

module lzssd_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic [7:0] i_in_byte,
    input logic       i_stream_start,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_run,
    input logic       o_bad_reference
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte)
            && $stable(o_last_of_run) && $stable(o_bad_reference)))
        else $error("stalled result beat changed");

    // bytes of one match share the error flag
    a_run_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last_of_run) ##1 !empty
            |-> (o_bad_reference == $past(o_bad_reference)))
        else $error("error flag changed inside a run");

endmodule

bind lzss_window_decompressor lzssd_chk u_chk (.*);
